/* src/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define BPA_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bpa assertion failed");

// Check that a condition never holds outside reset.
`define BPA_NEVER(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("bpa assertion failed");

`endif

/* src/bpa_pkg.sv */
`default_nettype none

package bpa_pkg;

  localparam int PW        = 36;
  localparam int CW        = 16;
  localparam int ORD_W     = 5;
  localparam int OUT_ORD_W = 4;
  localparam int OUT_CNT_W = 13;
  localparam int IN_DW     = 88;
  localparam int OUT_DW    = 56;
  localparam int REG_IDX_W = 1;

  localparam logic [REG_IDX_W-1:0] REG_HEAP_START = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_HEAP_END   = 1'b1;

  localparam logic PG_FREE = 1'b0;
  localparam logic PG_USED = 1'b1;

  typedef enum logic [1:0] {
    FN_ADD       = 2'd0,
    FN_ALLOC     = 2'd1,
    FN_ALLOC_LOW = 2'd2,
    FN_FREE      = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_NO_MEM     = 3'd1,
    STAT_BAD_COUNT  = 3'd2,
    STAT_RANGE      = 3'd3,
    STAT_MISALIGNED = 3'd4,
    STAT_DOUBLE     = 3'd5,
    STAT_IGNORED    = 3'd6
  } status_t;

  typedef enum logic [18:0] {
    S_IDLE  = 19'h00001,
    S_DEC   = 19'h00002,
    S_CHK   = 19'h00004,
    S_CARVE = 19'h00008,
    S_MARK  = 19'h00010,
    S_PUSHA = 19'h00020,
    S_PUSHB = 19'h00040,
    S_ULA   = 19'h00080,
    S_ULB   = 19'h00100,
    S_SPLIT = 19'h00200,
    S_LOW   = 19'h00400,
    S_LOWW  = 19'h00800,
    S_MERGE = 19'h01000,
    S_MPS   = 19'h02000,
    S_ILW   = 19'h04000,
    S_ILWW  = 19'h08000,
    S_MSTEP = 19'h10000,
    S_MFIN  = 19'h20000,
    S_FIN   = 19'h40000
  } state_t;

  // Smallest order whose block holds n pages.
  function automatic logic [ORD_W-1:0] order_of(input logic [CW-1:0] n);
    logic [ORD_W-1:0] r;
    r = '0;
    for (int o = CW; o >= 0; o--) begin
      if (({{CW{1'b0}}, 1'b1} << o) >= {1'b0, n}) r = ORD_W'(o);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/bpa_page_map.sv */
`default_nettype none

module bpa_page_map
  import bpa_pkg::*;
#(
  parameter int NUM_PAGES = 4096
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         wr_en,
  input  wire logic [$clog2(NUM_PAGES)-1:0] wr_addr,
  input  wire logic                         wr_val,
  input  wire logic [$clog2(NUM_PAGES)-1:0] rd_addr,
  output logic                              rd_val,
  output logic                              ready
);

  localparam int IW = $clog2(NUM_PAGES);

  logic          mem [NUM_PAGES];
  logic          clr_active;
  logic [IW-1:0] clr_addr;
  logic          we;
  logic [IW-1:0] wa;
  logic          wv;

  // Sweep every page to allocated after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + IW'(1);
      if (clr_addr == IW'(NUM_PAGES - 1)) clr_active <= 1'b0;
    end
  end

  always_comb begin
    we = clr_active ? 1'b1 : wr_en;
    wa = clr_active ? clr_addr : wr_addr;
    wv = clr_active ? PG_USED : wr_val;
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wv;
    rd_val <= mem[rd_addr];
  end

  assign ready = !clr_active;

endmodule

`default_nettype wire

/* src/buddy_page_allocator.sv */
`default_nettype none
// Buddy page allocator: one request per input transfer (add region, allocate,
// allocate lowest, free), one result per request through an output register.
// Page states, next links and previous links sit in synchronous memories;
// every list walk, page sweep and mark step is one memory access. An add
// checks each page of its range once, then marks and lists each block it
// carves; allocate lowest walks every listed block of the wanted order and
// above; free checks 2^order pages, then per merge step walks that order's
// list, and closes with a mark of the merged block's pages.
// After reset a clearing pass over all NUM_PAGES pages runs before the first
// request is taken; configuration writes take effect at once, so make them
// only while no request is in flight.

`include "assert_macros.svh"

module buddy_page_allocator
  import bpa_pkg::*;
#(
  parameter int NUM_PAGES = 4096,
  parameter int TOP_ORDER = 12
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [PW-1:0]        cfg_data,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // page_count[15:0], page_number[51:16], end_page[87:52]
  input  wire logic [IN_DW-1:0]     s_axis_tdata,
  // func[1:0]
  input  wire logic [1:0]           s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // result_page[35:0], result_order[39:36], free_page_count[52:40], zero
  output logic [OUT_DW-1:0]         m_axis_tdata,
  // status[2:0]
  output logic [2:0]                m_axis_tuser
);

  localparam int IW  = $clog2(NUM_PAGES);
  localparam int LW  = $clog2(NUM_PAGES + 1);
  localparam int OBW = $clog2(TOP_ORDER + 1);
  localparam int SW  = TOP_ORDER + 1;
  localparam logic [LW-1:0] NIL = LW'(NUM_PAGES);

  function automatic logic [LW-1:0] sat_idx(input logic [PW:0] v);
    if (v >= (PW+1)'(NUM_PAGES)) return NIL;
    return LW'(v);
  endfunction

  state_t          state;
  logic [PW-1:0]   heap_start_page;
  logic [PW-1:0]   heap_end_page;
  logic [LW-1:0]   head [TOP_ORDER+1];
  logic [LW-1:0]   len  [TOP_ORDER+1];
  logic [LW-1:0]   total;

  func_t           func_q;
  logic [CW-1:0]   cnt_q;
  logic [PW-1:0]   page_q;
  logic [PW-1:0]   endp_q;
  logic [ORD_W-1:0] ord_q;
  logic [PW-1:0]   cur_q;
  logic [PW-1:0]   hi_q;
  logic [ORD_W-1:0] o_q;
  logic [IW-1:0]   ck_idx;
  logic [LW-1:0]   ck_rem;
  logic            ck_pend;
  logic            ck_found;
  logic [LW-1:0]   mk_pos;
  logic [SW-1:0]   mk_rem;
  logic            mk_val;
  state_t          mk_ret;
  logic [LW-1:0]   pu_idx;
  logic [ORD_W-1:0] pu_o;
  logic [LW-1:0]   pu_h;
  state_t          pu_ret;
  logic [IW-1:0]   ul_idx;
  logic [ORD_W-1:0] ul_o;
  state_t          ul_ret;
  logic [LW-1:0]   best;
  logic [ORD_W-1:0] bo;
  logic [LW-1:0]   lk_cur;
  logic [LW-1:0]   lk_k;
  logic [IW-1:0]   bi_q;
  status_t         status_q;
  logic [PW-1:0]   rpage_q;
  logic [ORD_W-1:0] rord_q;
  logic            m_valid;

  logic [LW-1:0]   nx_mem [NUM_PAGES];
  logic [LW-1:0]   pv_mem [NUM_PAGES];
  logic [LW-1:0]   nx_rd;
  logic [LW-1:0]   pv_rd;
  logic            nx_we;
  logic [IW-1:0]   nx_wa;
  logic [LW-1:0]   nx_wd;
  logic [IW-1:0]   nx_ra;
  logic            pv_we;
  logic [IW-1:0]   pv_wa;
  logic [LW-1:0]   pv_wd;
  logic            ps_we;
  logic [IW-1:0]   ps_wa;
  logic            ps_wv;
  logic [IW-1:0]   ps_ra;
  logic            ps_rd;
  logic            pm_ready;

  logic [PW:0]      lim;
  logic [PW-1:0]    se;
  logic [PW-1:0]    lo;
  logic [PW-1:0]    hi;
  logic [ORD_W-1:0] ord_c;
  logic [PW:0]      sz_c;
  logic             misal;
  logic             hit;
  logic [ORD_W-1:0] sel;
  logic [PW-1:0]    crem;
  logic [ORD_W-1:0] osel;
  logic [PW:0]      ms;
  logic [PW-1:0]    mb;
  logic             mb_out;
  logic [ORD_W-1:0] o_inc;
  logic [ORD_W-1:0] f_dec;
  logic [LW-1:0]    cur_rel;
  logic [LW-1:0]    split_idx;

  always_comb begin
    lim   = {1'b0, heap_start_page} + (PW+1)'(NUM_PAGES);
    se    = ({1'b0, heap_end_page} < lim) ? heap_end_page : lim[PW-1:0];
    lo    = (page_q > heap_start_page) ? page_q : heap_start_page;
    hi    = (endp_q < se) ? endp_q : se;
    ord_c = order_of(cnt_q);
    sz_c  = (PW+1)'(1) << ord_c;
    misal = |(page_q & (sz_c[PW-1:0] - PW'(1)));
    hit = 1'b0;
    sel = '0;
    for (int o = TOP_ORDER; o >= 0; o--) begin
      if (ORD_W'(o) >= ord_c && len[o] != '0 && head[o] < NIL) begin
        hit = 1'b1;
        sel = ORD_W'(o);
      end
    end
    crem = hi_q - cur_q;
    osel = '0;
    for (int o = 0; o <= TOP_ORDER; o++) begin
      if ((cur_q & ((PW'(1) << o) - PW'(1))) == '0 && crem >= (PW'(1) << o))
        osel = ORD_W'(o);
    end
    ms        = (PW+1)'(1) << o_q;
    mb        = cur_q ^ ms[PW-1:0];
    mb_out    = (mb < heap_start_page) || (({1'b0, mb} + ms) > {1'b0, se});
    o_inc     = o_q + ORD_W'(1);
    f_dec     = o_q - ORD_W'(1);
    cur_rel   = sat_idx({1'b0, cur_q - heap_start_page});
    split_idx = sat_idx((PW+1)'(best) + ((PW+1)'(1) << f_dec));
  end

  always_comb begin
    ps_we = (state == S_MARK) && (mk_rem != '0) && (mk_pos < NIL);
    ps_wa = mk_pos[IW-1:0];
    ps_wv = mk_val;
    ps_ra = '0;
    nx_we = 1'b0;
    nx_wa = '0;
    nx_wd = '0;
    nx_ra = '0;
    pv_we = 1'b0;
    pv_wa = '0;
    pv_wd = '0;
    unique case (state)
      S_CHK:   ps_ra = ck_idx;
      S_MERGE: ps_ra = IW'(mb - heap_start_page);
      S_PUSHA: begin
        nx_we = (pu_idx != NIL);
        nx_wa = pu_idx[IW-1:0];
        nx_wd = head[pu_o[OBW-1:0]];
        pv_we = (pu_idx != NIL);
        pv_wa = pu_idx[IW-1:0];
        pv_wd = NIL;
      end
      S_PUSHB: begin
        pv_we = (pu_h < NIL);
        pv_wa = pu_h[IW-1:0];
        pv_wd = pu_idx;
      end
      S_ULA:   nx_ra = ul_idx;
      S_ULB: begin
        nx_we = (pv_rd < NIL);
        nx_wa = pv_rd[IW-1:0];
        nx_wd = nx_rd;
        pv_we = (nx_rd < NIL);
        pv_wa = nx_rd[IW-1:0];
        pv_wd = pv_rd;
      end
      S_LOW:   nx_ra = lk_cur[IW-1:0];
      S_ILW:   nx_ra = lk_cur[IW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (nx_we) nx_mem[nx_wa] <= nx_wd;
    nx_rd <= nx_mem[nx_ra];
  end

  always_ff @(posedge clk) begin
    if (pv_we) pv_mem[pv_wa] <= pv_wd;
    pv_rd <= pv_mem[ul_idx];
  end

  bpa_page_map #(
    .NUM_PAGES(NUM_PAGES)
  ) u_page_map (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (ps_we),
    .wr_addr (ps_wa),
    .wr_val  (ps_wv),
    .rd_addr (ps_ra),
    .rd_val  (ps_rd),
    .ready   (pm_ready)
  );

  assign s_axis_tready = (state == S_IDLE) && pm_ready;
  assign m_axis_tvalid = m_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      m_valid         <= 1'b0;
      total           <= '0;
      heap_start_page <= '0;
      heap_end_page   <= '0;
      for (int o = 0; o <= TOP_ORDER; o++) begin
        head[o] <= NIL;
        len[o]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_HEAP_START) heap_start_page <= cfg_data;
        else heap_end_page <= cfg_data;
      end
      if (m_valid && m_axis_tready && state != S_FIN) m_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            func_q   <= func_t'(s_axis_tuser);
            cnt_q    <= s_axis_tdata[15:0];
            page_q   <= s_axis_tdata[51:16];
            endp_q   <= s_axis_tdata[87:52];
            status_q <= STAT_OK;
            rpage_q  <= '0;
            rord_q   <= '0;
            state    <= S_DEC;
          end
        end

        S_DEC: begin
          ord_q    <= ord_c;
          ck_pend  <= 1'b0;
          ck_found <= 1'b0;
          unique case (func_q) inside
            FN_ADD: begin
              if (lo >= hi) begin
                status_q <= STAT_IGNORED;
                state    <= S_FIN;
              end else begin
                cur_q  <= lo;
                hi_q   <= hi;
                ck_idx <= IW'(lo - heap_start_page);
                ck_rem <= LW'(hi - lo);
                state  <= S_CHK;
              end
            end
            FN_ALLOC, FN_ALLOC_LOW: begin
              if (cnt_q == '0 || ord_c > ORD_W'(TOP_ORDER)) begin
                status_q <= STAT_BAD_COUNT;
                state    <= S_FIN;
              end else if (func_q == FN_ALLOC) begin
                if (!hit) begin
                  status_q <= STAT_NO_MEM;
                  state    <= S_FIN;
                end else begin
                  best   <= head[sel[OBW-1:0]];
                  o_q    <= sel;
                  ul_idx <= head[sel[OBW-1:0]][IW-1:0];
                  ul_o   <= sel;
                  ul_ret <= S_SPLIT;
                  state  <= S_ULA;
                end
              end else begin
                best   <= NIL;
                bo     <= '0;
                o_q    <= ord_c;
                lk_cur <= head[ord_c[OBW-1:0]];
                lk_k   <= '0;
                state  <= S_LOW;
              end
            end
            FN_FREE: begin
              if (cnt_q == '0) begin
                status_q <= STAT_BAD_COUNT;
                state    <= S_FIN;
              end else if (page_q < heap_start_page || page_q >= se) begin
                status_q <= STAT_RANGE;
                state    <= S_FIN;
              end else if (ord_c > ORD_W'(TOP_ORDER)) begin
                status_q <= STAT_BAD_COUNT;
                state    <= S_FIN;
              end else if (misal) begin
                status_q <= STAT_MISALIGNED;
                state    <= S_FIN;
              end else if (({1'b0, page_q} + sz_c) > {1'b0, se}) begin
                status_q <= STAT_RANGE;
                state    <= S_FIN;
              end else begin
                cur_q  <= page_q;
                o_q    <= ord_c;
                ck_idx <= IW'(page_q - heap_start_page);
                ck_rem <= LW'(sz_c);
                state  <= S_CHK;
              end
            end
            default: state <= S_FIN;
          endcase
        end

        S_CHK: begin
          if (ck_rem != '0) begin
            ck_idx <= ck_idx + IW'(1);
            ck_rem <= ck_rem - LW'(1);
          end
          ck_pend <= (ck_rem != '0);
          if (ck_pend && ps_rd == PG_FREE) ck_found <= 1'b1;
          if (ck_rem == '0 && !ck_pend) begin
            if (ck_found) begin
              status_q <= STAT_DOUBLE;
              state    <= S_FIN;
            end else if (func_q == FN_ADD) begin
              state <= S_CARVE;
            end else begin
              state <= S_MERGE;
            end
          end
        end

        S_CARVE: begin
          if (cur_q < hi_q) begin
            mk_pos <= cur_rel;
            mk_rem <= SW'(1) << osel;
            mk_val <= PG_FREE;
            mk_ret <= S_PUSHA;
            pu_idx <= cur_rel;
            pu_o   <= osel;
            pu_ret <= S_CARVE;
            total  <= total + (LW'(1) << osel);
            cur_q  <= cur_q + (PW'(1) << osel);
            state  <= S_MARK;
          end else begin
            state <= S_FIN;
          end
        end

        S_MARK: begin
          if (mk_rem != '0 && mk_pos < NIL) begin
            mk_pos <= mk_pos + LW'(1);
            mk_rem <= mk_rem - SW'(1);
          end else begin
            state <= mk_ret;
          end
        end

        S_PUSHA: begin
          if (pu_idx == NIL) begin
            state <= pu_ret;
          end else begin
            pu_h                  <= head[pu_o[OBW-1:0]];
            head[pu_o[OBW-1:0]]   <= pu_idx;
            len[pu_o[OBW-1:0]]    <= len[pu_o[OBW-1:0]] + LW'(1);
            state                 <= S_PUSHB;
          end
        end

        S_PUSHB: state <= pu_ret;

        S_ULA: state <= S_ULB;

        S_ULB: begin
          if (pv_rd >= NIL) head[ul_o[OBW-1:0]] <= nx_rd;
          if (len[ul_o[OBW-1:0]] != '0)
            len[ul_o[OBW-1:0]] <= len[ul_o[OBW-1:0]] - LW'(1);
          state <= ul_ret;
        end

        S_SPLIT: begin
          if (o_q > ord_q) begin
            o_q    <= f_dec;
            mk_pos <= split_idx;
            mk_rem <= SW'(1) << f_dec;
            mk_val <= PG_FREE;
            mk_ret <= S_PUSHA;
            pu_idx <= split_idx;
            pu_o   <= f_dec;
            pu_ret <= S_SPLIT;
            state  <= S_MARK;
          end else begin
            mk_pos  <= sat_idx((PW+1)'(best));
            mk_rem  <= SW'(1) << ord_q;
            mk_val  <= PG_USED;
            mk_ret  <= S_FIN;
            total   <= total - (LW'(1) << ord_q);
            rpage_q <= heap_start_page + PW'(best);
            rord_q  <= ord_q;
            state   <= S_MARK;
          end
        end

        S_LOW: begin
          if (lk_k < len[o_q[OBW-1:0]] && lk_cur < NIL) begin
            if (lk_cur < best) begin
              best <= lk_cur;
              bo   <= o_q;
            end
            lk_k  <= lk_k + LW'(1);
            state <= S_LOWW;
          end else if (o_q == ORD_W'(TOP_ORDER)) begin
            if (best == NIL) begin
              status_q <= STAT_NO_MEM;
              state    <= S_FIN;
            end else begin
              ul_idx <= best[IW-1:0];
              ul_o   <= bo;
              ul_ret <= S_SPLIT;
              o_q    <= bo;
              state  <= S_ULA;
            end
          end else begin
            o_q    <= o_inc;
            lk_cur <= head[o_inc[OBW-1:0]];
            lk_k   <= '0;
          end
        end

        S_LOWW: begin
          lk_cur <= nx_rd;
          state  <= S_LOW;
        end

        S_MERGE: begin
          if (o_q < ORD_W'(TOP_ORDER) && !mb_out) begin
            bi_q  <= IW'(mb - heap_start_page);
            state <= S_MPS;
          end else begin
            state <= S_MFIN;
          end
        end

        S_MPS: begin
          if (ps_rd != PG_FREE) begin
            state <= S_MFIN;
          end else begin
            lk_cur <= head[o_q[OBW-1:0]];
            lk_k   <= '0;
            state  <= S_ILW;
          end
        end

        S_ILW: begin
          if (lk_k < len[o_q[OBW-1:0]] && lk_cur < NIL) begin
            if (lk_cur == LW'(bi_q)) begin
              ul_idx <= bi_q;
              ul_o   <= o_q;
              ul_ret <= S_MSTEP;
              state  <= S_ULA;
            end else begin
              lk_k  <= lk_k + LW'(1);
              state <= S_ILWW;
            end
          end else begin
            state <= S_MFIN;
          end
        end

        S_ILWW: begin
          lk_cur <= nx_rd;
          state  <= S_ILW;
        end

        S_MSTEP: begin
          cur_q <= cur_q & ~ms[PW-1:0];
          o_q   <= o_inc;
          state <= S_MERGE;
        end

        S_MFIN: begin
          mk_pos <= cur_rel;
          mk_rem <= SW'(1) << o_q;
          mk_val <= PG_FREE;
          mk_ret <= S_PUSHA;
          pu_idx <= cur_rel;
          pu_o   <= o_q;
          pu_ret <= S_FIN;
          total  <= total + (LW'(1) << ord_q);
          rord_q <= ord_q;
          state  <= S_MARK;
        end

        S_FIN: begin
          if (!m_valid || m_axis_tready) begin
            m_valid      <= 1'b1;
            m_axis_tdata <= {3'b000, OUT_CNT_W'(total), OUT_ORD_W'(rord_q), rpage_q};
            m_axis_tuser <= status_q;
            state        <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  `BPA_ASSERT(a_take_leaves_idle, clk, rst, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
  `BPA_ASSERT(a_result_from_fin, clk, rst, $rose(m_axis_tvalid) |-> $past(state == S_FIN))
  `BPA_ASSERT(a_error_zero_payload, clk, rst, (m_axis_tvalid && m_axis_tuser != STAT_OK) |-> (m_axis_tdata[39:0] == 40'd0))
  `BPA_NEVER(a_no_write_in_clear, clk, rst, ps_we && !pm_ready)

endmodule

`default_nettype wire
